/* hw/rtl/ipcs_pkg.sv */
package ipcs_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_SERVER_MODE = 1'b0;

  localparam logic [15:0] MIN_LENGTH   = 16'd20;
  localparam logic [7:0]  VERSION_MASK = 8'hF0;
  localparam logic [7:0]  VERSION_FOUR = 8'h40;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_BAD_VER  = 2'd2;
  localparam logic [1:0] ST_BAD_CHAN = 2'd3;

  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_TCP   = 2'd1;
  localparam logic [1:0] CLS_UDP   = 2'd2;

  typedef struct packed {
    logic [15:0] packet_length;
    logic [7:0]  version_byte;
    logic [7:0]  protocol_byte;
    logic [7:0]  byte_fifteen;
    logic [7:0]  byte_nineteen;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  traffic_class;
    logic [5:0]  channel;
    logic [31:0] reorder_seq;
    logic [31:0] data_seq;
    logic [31:0] total_packets;
    logic [47:0] total_bytes;
    logic [31:0] chan_packets;
    logic [47:0] chan_bytes;
    logic [31:0] chan_class_packets;
    logic [47:0] chan_class_bytes;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  traffic_class;
    logic [5:0]  channel;
    logic [15:0] packet_length;
    logic        server_mode;
  } cls_word_t;

endpackage

/* hw/rtl/ipcs_front.sv */
module ipcs_front
  import ipcs_pkg::*;
(
  input  logic      server_mode,
  input  in_word_t  in_word,
  output cls_word_t cls_word
);

  logic [7:0] sel;
  logic [5:0] chan;
  logic [1:0] status;
  logic [1:0] cls;

  always_comb begin
    sel  = server_mode ? in_word.byte_nineteen : in_word.byte_fifteen;
    chan = sel[7:2];
    if (in_word.packet_length < MIN_LENGTH) begin
      status = ST_SHORT;
    end else if ((in_word.version_byte & VERSION_MASK) != VERSION_FOUR) begin
      status = ST_BAD_VER;
    end else if ({1'b0, chan} >= 7'(NUM_CHANNELS)) begin
      status = ST_BAD_CHAN;
    end else begin
      status = ST_OK;
    end
    if (status != ST_OK) begin
      cls = CLS_OTHER;
    end else if (in_word.protocol_byte == PROTO_TCP) begin
      cls = CLS_TCP;
    end else if (in_word.protocol_byte == PROTO_UDP) begin
      cls = CLS_UDP;
    end else begin
      cls = CLS_OTHER;
    end
    cls_word.status        = status;
    cls_word.traffic_class = cls;
    cls_word.channel       = chan;
    cls_word.packet_length = in_word.packet_length;
    cls_word.server_mode   = server_mode;
  end

endmodule

/* hw/rtl/ipcs_queue.sv */
module ipcs_queue
  import ipcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cls_word_t push_word,
  output logic      not_full,
  input  logic      pop,
  output logic      not_empty,
  output cls_word_t head_word
);

  cls_word_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign not_full  = (count_r != QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head_word = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

/* hw/rtl/ipcs_back.sv */
module ipcs_back
  import ipcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_not_empty,
  input  cls_word_t q_word,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic [31:0] udp_seq_r, tcp_seq_r, data_seq_r, pkt_cnt_r;
  logic [47:0] byte_cnt_r;
  logic [31:0] ch_pkt_r     [NUM_CHANNELS];
  logic [47:0] ch_byte_r    [NUM_CHANNELS];
  logic [31:0] ch_tcp_pkt_r [NUM_CHANNELS];
  logic [47:0] ch_tcp_byte_r[NUM_CHANNELS];
  logic [31:0] ch_udp_pkt_r [NUM_CHANNELS];
  logic [47:0] ch_udp_byte_r[NUM_CHANNELS];

  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_data_r, out_data_nxt;

  logic [CH_IDX_W-1:0] ci;
  logic        ok, is_tcp, is_udp, ch_upd;
  logic [47:0] len48;
  logic [31:0] pkt_cnt_nxt, cp_nxt, tp_nxt, up_nxt;
  logic [47:0] byte_cnt_nxt, cb_nxt, tb_nxt, ub_nxt;

  assign q_pop     = q_not_empty && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    ci     = q_word.channel[CH_IDX_W-1:0];
    ok     = (q_word.status == ST_OK);
    is_tcp = ok && (q_word.traffic_class == CLS_TCP);
    is_udp = ok && (q_word.traffic_class == CLS_UDP);
    ch_upd = ok && q_word.server_mode;
    len48  = 48'(q_word.packet_length);

    pkt_cnt_nxt  = ok ? pkt_cnt_r + 32'd1 : pkt_cnt_r;
    byte_cnt_nxt = ok ? byte_cnt_r + len48 : byte_cnt_r;
    cp_nxt = ch_upd ? ch_pkt_r[ci] + 32'd1 : ch_pkt_r[ci];
    cb_nxt = ch_upd ? ch_byte_r[ci] + len48 : ch_byte_r[ci];
    tp_nxt = (ch_upd && is_tcp) ? ch_tcp_pkt_r[ci] + 32'd1 : ch_tcp_pkt_r[ci];
    tb_nxt = (ch_upd && is_tcp) ? ch_tcp_byte_r[ci] + len48 : ch_tcp_byte_r[ci];
    up_nxt = (ch_upd && is_udp) ? ch_udp_pkt_r[ci] + 32'd1 : ch_udp_pkt_r[ci];
    ub_nxt = (ch_upd && is_udp) ? ch_udp_byte_r[ci] + len48 : ch_udp_byte_r[ci];

    out_data_nxt.status        = q_word.status;
    out_data_nxt.traffic_class = q_word.traffic_class;
    out_data_nxt.channel       = q_word.channel;
    out_data_nxt.reorder_seq   = is_tcp ? tcp_seq_r : (is_udp ? udp_seq_r : 32'd0);
    out_data_nxt.data_seq      = ok ? data_seq_r : 32'd0;
    out_data_nxt.total_packets = pkt_cnt_nxt;
    out_data_nxt.total_bytes   = byte_cnt_nxt;
    out_data_nxt.chan_packets  = ok ? cp_nxt : 32'd0;
    out_data_nxt.chan_bytes    = ok ? cb_nxt : 48'd0;
    out_data_nxt.chan_class_packets = is_tcp ? tp_nxt : (is_udp ? up_nxt : 32'd0);
    out_data_nxt.chan_class_bytes   = is_tcp ? tb_nxt : (is_udp ? ub_nxt : 48'd0);

    out_valid_nxt = q_pop ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      udp_seq_r   <= '0;
      tcp_seq_r   <= '0;
      data_seq_r  <= '0;
      pkt_cnt_r   <= '0;
      byte_cnt_r  <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        ch_pkt_r[i]      <= '0;
        ch_byte_r[i]     <= '0;
        ch_tcp_pkt_r[i]  <= '0;
        ch_tcp_byte_r[i] <= '0;
        ch_udp_pkt_r[i]  <= '0;
        ch_udp_byte_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop && ok) begin
        pkt_cnt_r  <= pkt_cnt_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        data_seq_r <= data_seq_r + 32'd1;
        if (is_tcp) begin
          tcp_seq_r <= tcp_seq_r + 32'd1;
        end
        if (is_udp) begin
          udp_seq_r <= udp_seq_r + 32'd1;
        end
        if (ch_upd) begin
          ch_pkt_r[ci]      <= cp_nxt;
          ch_byte_r[ci]     <= cb_nxt;
          ch_tcp_pkt_r[ci]  <= tp_nxt;
          ch_tcp_byte_r[ci] <= tb_nxt;
          ch_udp_pkt_r[ci]  <= up_nxt;
          ch_udp_byte_r[ci] <= ub_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* hw/rtl/ipv4_packet_classify_stamp_core.sv */
// IPv4 receive classifier with sequence stamping and traffic counters.
// Input channel (in_valid/in_ready/in_data): one word per packet, carrying the
// length and header bytes 0, 9, 15 and 19. Result channel (out_valid/
// out_ready/out_data): one word per input word, in order, with status, class,
// channel, stamped sequence numbers and the counter values after the packet.
// Config port (cfg_*): APB-style, one register (server_mode, bit 0), selected
// at addresses 0 to 3. Write only while no word is in flight.
// Path: an accepted word goes into the queue, then into the output register.
// Throughput: one word per cycle while out_ready allows; the read-modify-write
// of the global counters and the per-channel counter bank at each pop sets the rate.
// A two-entry queue sits between the classifier and the counter stage, and
// the result is held in an output register, so a stalled receiver fills the
// output register, then the queue, and only then drops in_ready.
// Reset (rst_n, synchronous, active low) clears server_mode, all sequence
// numbers, totals and per-channel counters and empties the pipeline; the
// block takes words in the first cycle after reset.
module ipv4_packet_classify_stamp_core
  import ipcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  logic      server_mode_r;
  cls_word_t cls_word, head_word;
  logic      q_not_full, q_not_empty, q_pop;
  logic      reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[CFG_ADDR_W-1] == REG_SERVER_MODE);
  assign cfg_prdata = reg_sel ? {31'd0, server_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      server_mode_r <= cfg_pwdata[0];
    end
  end

  assign in_ready = q_not_full;

  ipcs_front u_front (
    .server_mode (server_mode_r),
    .in_word     (in_data),
    .cls_word    (cls_word)
  );

  ipcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_word (cls_word),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_word (head_word)
  );

  ipcs_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_word      (head_word),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.traffic_class == CLS_OTHER && out_data.data_seq == 32'd0 &&
      out_data.chan_packets == 32'd0)
    else $error("rejected packet carries stamps");

  a_other_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.traffic_class == CLS_OTHER |->
      out_data.reorder_seq == 32'd0 && out_data.chan_class_packets == 32'd0)
    else $error("other traffic carries class stamps");

  a_ok_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_OK |->
      {1'b0, out_data.channel} < 7'(NUM_CHANNELS))
    else $error("accepted packet with channel out of range");

endmodule
